@@ src/r2y_pkg.sv @@
// Shared types and constants for the RGB to YUV 4:2:0 stream converter.
// No dependencies; used by the front, chroma and top modules of the block.
package r2y_pkg;

	// configuration register: pixel pairs per row
	localparam int CFG_W       = 12;
	localparam int PAIRS_RESET = 320;

	// default line buffer depth in pixel pairs
	localparam int MAX_PAIRS_DEFAULT = 2048;

	// packed pair sum: R in [8:0], G in [17:9], B in [26:18]
	localparam int FIELD_W = 9;
	localparam int SUM_W   = 3 * FIELD_W;

	// word handed from the front stage to the chroma stage
	typedef struct packed {
		logic [7:0]       luma;
		logic             chroma_en;
		logic [SUM_W-1:0] pair_sum;
	} s1_t;

endpackage

@@ src/r2y_front.sv @@
// Front stage: frame/row/column tracking, pair summing, line buffer and luma.
// Depends on r2y_pkg.
module r2y_front #(
	parameter int MAX_PAIRS_PER_ROW = r2y_pkg::MAX_PAIRS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  red,
	input  logic [7:0]                  green,
	input  logic [7:0]                  blue,
	input  logic                        start_of_frame,
	input  logic [r2y_pkg::CFG_W-1:0]   pairs_per_row,
	output r2y_pkg::s1_t                word_s1,
	output logic [r2y_pkg::SUM_W-1:0]   above_s1
);

	localparam int ADDR_W = (MAX_PAIRS_PER_ROW > 1) ? $clog2(MAX_PAIRS_PER_ROW) : 1;
	localparam int CNT_W  = $clog2(MAX_PAIRS_PER_ROW + 1);
	localparam int WW     = ((CNT_W > r2y_pkg::CFG_W) ? CNT_W : r2y_pkg::CFG_W) + 1;
	localparam int SUM_W  = r2y_pkg::SUM_W;

	localparam logic [16:0] LUMA_KR = 17'd77;
	localparam logic [16:0] LUMA_KG = 17'd150;
	localparam logic [16:0] LUMA_KB = 17'd29;

	logic [ADDR_W-1:0] col_q;
	logic              phase_q;
	logic              odd_q;
	logic [SUM_W-1:0]  pair_q;

	logic [SUM_W-1:0]  line_mem [MAX_PAIRS_PER_ROW];

	logic [ADDR_W-1:0] col_cur;
	logic              phase_cur;
	logic              odd_cur;
	logic [SUM_W-1:0]  pixel;
	logic [SUM_W-1:0]  total;
	logic [WW-1:0]     eff_width;
	logic [WW-1:0]     col_inc;
	logic              wrap;
	logic              mem_we;
	logic              mem_re;
	logic [16:0]       luma_acc;

	// start of frame clears position before this pixel is used
	assign col_cur   = start_of_frame ? '0 : col_q;
	assign phase_cur = start_of_frame ? 1'b0 : phase_q;
	assign odd_cur   = start_of_frame ? 1'b0 : odd_q;

	assign pixel = {1'b0, blue, 1'b0, green, 1'b0, red};
	// fields cannot carry into each other: 255 + 255 < 512
	assign total = pair_q + pixel;

	// effective width: zero acts as one, clamp to line buffer depth
	always_comb begin
		eff_width = WW'(pairs_per_row);
		if (eff_width == '0) begin
			eff_width = WW'(1);
		end else if (eff_width > WW'(MAX_PAIRS_PER_ROW)) begin
			eff_width = WW'(MAX_PAIRS_PER_ROW);
		end
	end

	assign col_inc = WW'(col_cur) + WW'(1);
	assign wrap    = (col_inc >= eff_width);

	assign mem_we = accept && phase_cur && !odd_cur;
	assign mem_re = accept && phase_cur && odd_cur;

	// luma, full range BT.601; sum peaks at 256 * 255 + 128, fits 17 bits
	assign luma_acc = LUMA_KR * 17'(red) + LUMA_KG * 17'(green)
		+ LUMA_KB * 17'(blue) + 17'd128;

	// position and pair state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			phase_q <= 1'b0;
			odd_q   <= 1'b0;
			pair_q  <= '0;
		end else if (accept) begin
			if (!phase_cur) begin
				pair_q  <= pixel;
				phase_q <= 1'b1;
				col_q   <= col_cur;
				odd_q   <= odd_cur;
			end else begin
				pair_q  <= total;
				phase_q <= 1'b0;
				col_q   <= wrap ? '0 : col_inc[ADDR_W-1:0];
				odd_q   <= wrap ? !odd_cur : odd_cur;
			end
		end
	end

	// line buffer: even rows write, odd rows read the pair above
	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[col_cur] <= total;
		end
		if (mem_re) begin
			above_s1 <= line_mem[col_cur];
		end
	end

	// stage register
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1.luma      <= luma_acc[15:8];
			word_s1.chroma_en <= phase_cur && odd_cur;
			word_s1.pair_sum  <= total;
		end
	end

endmodule

@@ src/r2y_chroma.sv @@
// Chroma stage: 2x2 block averages, Cb/Cr with floor shifts and clamping,
// and the result register. Depends on r2y_pkg.
module r2y_chroma (
	input  logic                      clk,
	input  logic                      load,
	input  r2y_pkg::s1_t              word_s1,
	input  logic [r2y_pkg::SUM_W-1:0] above_s1,
	output logic [7:0]                luma,
	output logic                      chroma_valid,
	output logic [7:0]                blue_difference,
	output logic [7:0]                red_difference
);

	localparam int FW = r2y_pkg::FIELD_W;

	logic [FW:0]        r_sum, g_sum, b_sum;
	logic [7:0]         ra, ga, ba;
	logic signed [17:0] t_cb, t_cr;
	logic [7:0]         cb, cr;

	// floor(t / 256) + 128, clamped to 0..255
	function automatic logic [7:0] clamp_chroma(input logic signed [17:0] t);
		logic signed [9:0] c;
		c = $signed(t[17:8]) + 10'sd128;
		if (c < 10'sd0) begin
			return 8'd0;
		end else if (c > 10'sd255) begin
			return 8'd255;
		end
		return c[7:0];
	endfunction

	// block averages from the pair above and the current pair
	assign r_sum = {1'b0, above_s1[FW-1:0]}      + {1'b0, word_s1.pair_sum[FW-1:0]};
	assign g_sum = {1'b0, above_s1[2*FW-1:FW]}   + {1'b0, word_s1.pair_sum[2*FW-1:FW]};
	assign b_sum = {1'b0, above_s1[3*FW-1:2*FW]} + {1'b0, word_s1.pair_sum[3*FW-1:2*FW]};
	assign ra = r_sum[FW:2];
	assign ga = g_sum[FW:2];
	assign ba = b_sum[FW:2];

	assign t_cb = $signed({10'd0, ba}) * 18'sd128 - $signed({10'd0, ra}) * 18'sd43
		- $signed({10'd0, ga}) * 18'sd84 + 18'sd128;
	assign t_cr = $signed({10'd0, ra}) * 18'sd128 - $signed({10'd0, ga}) * 18'sd107
		- $signed({10'd0, ba}) * 18'sd21 + 18'sd128;

	assign cb = word_s1.chroma_en ? clamp_chroma(t_cb) : 8'd0;
	assign cr = word_s1.chroma_en ? clamp_chroma(t_cr) : 8'd0;

	// result register
	always_ff @(posedge clk) begin
		if (load) begin
			luma            <= word_s1.luma;
			chroma_valid    <= word_s1.chroma_en;
			blue_difference <= cb;
			red_difference  <= cr;
		end
	end

endmodule

@@ src/rgb_to_yuv420_stream_unit.sv @@
// Top level of the RGB to YUV 4:2:0 stream converter: handshake, width register.
// Depends on r2y_pkg, r2y_front and r2y_chroma.
//
// Takes one RGB pixel per clock in raster order and returns one word per pixel:
// its luma, and on the second pixel of each pair in an odd row the Cb/Cr of
// the completed 2x2 block (chroma_valid high; otherwise Cb/Cr read zero).
// Sustained rate is one pixel per cycle; each accepted pixel is registered in
// the front stage (line buffer read, pair sum, luma) and then in the chroma
// stage before its result is valid. Two words can be held inside, so input is
// stalled only when both stages are full and the output is stalled.
// pairs_per_row (pixel pairs per row, zero acts as one, larger than the line
// buffer acts as its depth) must be written only while the block is idle, which
// the block itself does not enforce; cfg_ready is always high. start_of_frame
// restarts row and column; an odd final row gives no chroma. The line buffer
// holds MAX_PAIRS_PER_ROW pair sums and needs no clearing after reset.
module rgb_to_yuv420_stream_unit #(
	parameter int MAX_PAIRS_PER_ROW = r2y_pkg::MAX_PAIRS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [r2y_pkg::CFG_W-1:0] pairs_per_row,
	// pixel input
	input  logic                      pixel_valid,
	output logic                      pixel_stall,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic                      start_of_frame,
	// result output
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [7:0]                luma,
	output logic                      chroma_valid,
	output logic [7:0]                blue_difference,
	output logic [7:0]                red_difference
);

	logic [r2y_pkg::CFG_W-1:0] pairs_q;
	logic                      s1_valid_q;
	logic                      out_valid_q;
	logic                      out_load;
	logic                      accept;
	r2y_pkg::s1_t              word_s1;
	logic [r2y_pkg::SUM_W-1:0] above_s1;

	// width register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= r2y_pkg::CFG_W'(r2y_pkg::PAIRS_RESET);
		end else if (cfg_valid) begin
			pairs_q <= pairs_per_row;
		end
	end

	// pipeline flow control
	assign out_load    = !out_valid_q || !result_stall;
	assign pixel_stall = s1_valid_q && !out_load;
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (out_load) begin
				s1_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	assign result_valid = out_valid_q;

	r2y_front #(
		.MAX_PAIRS_PER_ROW(MAX_PAIRS_PER_ROW)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.start_of_frame (start_of_frame),
		.pairs_per_row  (pairs_q),
		.word_s1        (word_s1),
		.above_s1       (above_s1)
	);

	r2y_chroma u_chroma (
		.clk             (clk),
		.load            (out_load && s1_valid_q),
		.word_s1         (word_s1),
		.above_s1        (above_s1),
		.luma            (luma),
		.chroma_valid    (chroma_valid),
		.blue_difference (blue_difference),
		.red_difference  (red_difference)
	);

endmodule

@@ src/r2y_checker.sv @@
// Port-level checks for the RGB to YUV 4:2:0 stream converter, bound to the top.
// Depends on rgb_to_yuv420_stream_unit.
module r2y_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      pixel_valid,
	input logic                      pixel_stall,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic                      chroma_valid,
	input logic [7:0]                blue_difference,
	input logic [7:0]                red_difference
);

	// a stalled result word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result word dropped while stalled");

	// input only stalls when a result is waiting at a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> result_valid && result_stall)
		else $error("input stalled without output backpressure");

	// an accepted word passes the stage register and reaches the output when not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && !pixel_stall) ##1 !result_stall |=> result_valid)
		else $error("accepted word did not reach the output");

	// chroma fields are zero on words that close no block
	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !chroma_valid |-> blue_difference == 8'd0 && red_difference == 8'd0)
		else $error("chroma nonzero without a completed block");

endmodule

bind rgb_to_yuv420_stream_unit r2y_checker u_r2y_checker (.*);

@@ tb/yuv420_checker.sv @@
// Checker for the RGB to YUV 4:2:0 stream converter: watches the config, pixel
// and result channels, predicts every result word and compares it field by field.
// Depends on r2y_pkg.
module yuv420_checker #(
	parameter int MAX_PAIRS = r2y_pkg::MAX_PAIRS_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [r2y_pkg::CFG_W-1:0] pairs_per_row,
	input  logic                      pixel_valid,
	input  logic                      pixel_stall,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	input  logic                      start_of_frame,
	input  logic                      result_valid,
	input  logic                      result_stall,
	input  logic [7:0]                luma,
	input  logic                      chroma_valid,
	input  logic [7:0]                blue_difference,
	input  logic [7:0]                red_difference,
	output int                        mismatches,
	output int                        pending,
	output int                        blocks_seen
);

	localparam int FW = r2y_pkg::FIELD_W;
	localparam int SW = r2y_pkg::SUM_W;

	// one predicted result word
	typedef struct packed {
		logic [7:0] luma;
		logic       chroma;
		logic [7:0] cb;
		logic [7:0] cr;
	} yuv_word_t;

	yuv_word_t                 expected_words[$];
	yuv_word_t                 want;
	logic [r2y_pkg::CFG_W-1:0] width_reg;
	int                        column;
	logic                      odd_row;
	logic                      second_pixel;
	logic [SW-1:0]             pair_acc;
	logic [SW-1:0]             even_row_sums [MAX_PAIRS];

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		$display("checker: %s got %0d expected %0d at %0t", what, got, exp_val, $time);
		mismatches++;
	endtask

	// floor(t / 256) + 128, clamped to a byte
	function automatic logic [7:0] chroma_clamp(input int t);
		int v;
		v = (t >>> 8) + 128;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	// advance the converter state by one pixel and build its result word
	task automatic convert_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic sof, output yuv_word_t w);
		int            eff_width;
		int            ra;
		int            ga;
		int            ba;
		logic [SW-1:0] above;
		logic [SW-1:0] pix;
		eff_width = (width_reg == 0) ? 1 :
			((width_reg > MAX_PAIRS) ? MAX_PAIRS : int'(width_reg));
		pix = {1'b0, b, 1'b0, g, 1'b0, r};
		w = '0;
		if (sof) begin
			column = 0;
			second_pixel = 1'b0;
			odd_row = 1'b0;
		end
		w.luma = 8'((77 * r + 150 * g + 29 * b + 128) >> 8);
		if (!second_pixel) begin
			pair_acc = pix;
			second_pixel = 1'b1;
		end else begin
			pair_acc = pair_acc + pix;
			if (!odd_row) begin
				even_row_sums[column] = pair_acc;
			end else begin
				// block averages from the stored even-row pair and this pair
				above = even_row_sums[column];
				ra = (above[FW-1:0] + pair_acc[FW-1:0]) >> 2;
				ga = (above[2*FW-1:FW] + pair_acc[2*FW-1:FW]) >> 2;
				ba = (above[SW-1:2*FW] + pair_acc[SW-1:2*FW]) >> 2;
				w.chroma = 1'b1;
				w.cb = chroma_clamp(128 * ba + 128 - 43 * ra - 84 * ga);
				w.cr = chroma_clamp(128 * ra + 128 - 107 * ga - 21 * ba);
			end
			second_pixel = 1'b0;
			column++;
			if (column >= eff_width) begin
				column = 0;
				odd_row = ~odd_row;
			end
		end
	endtask

	// track config, queue predictions on accepted pixels, check accepted words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = r2y_pkg::CFG_W'(r2y_pkg::PAIRS_RESET);
			column = 0;
			odd_row = 1'b0;
			second_pixel = 1'b0;
			pair_acc = '0;
			expected_words.delete();
			mismatches = 0;
			blocks_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) width_reg = pairs_per_row;
			if (pixel_valid && !pixel_stall) begin
				convert_pixel(red, green, blue, start_of_frame, want);
				expected_words.push_back(want);
			end
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word, luma", luma, 0);
				end else begin
					want = expected_words.pop_front();
					if (luma !== want.luma)
						report_mismatch("luma", luma, want.luma);
					if (chroma_valid !== want.chroma)
						report_mismatch("chroma_valid", chroma_valid, want.chroma);
					if (blue_difference !== want.cb)
						report_mismatch("blue_difference", blue_difference, want.cb);
					if (red_difference !== want.cr)
						report_mismatch("red_difference", red_difference, want.cr);
					if (want.chroma) blocks_seen++;
				end
			end
		end
		pending = expected_words.size();
	end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the RGB to YUV 4:2:0 stream converter: clock, reset,
// width writes, pixel stimulus, result back-pressure and the verdict.
// Depends on r2y_pkg, rgb_to_yuv420_stream_unit and yuv420_checker.
module tb_top;

	localparam int CLK_HALF   = 10;
	localparam int HOLD_OFF   = 60;
	localparam int DRAIN_WAIT = 6;
	localparam int WIDE_PIXELS = 80;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [r2y_pkg::CFG_W-1:0] pairs_per_row;
	logic                      pixel_valid;
	logic                      pixel_stall;
	logic [7:0]                red;
	logic [7:0]                green;
	logic [7:0]                blue;
	logic                      start_of_frame;
	logic                      result_valid;
	logic                      result_stall;
	logic [7:0]                luma;
	logic                      chroma_valid;
	logic [7:0]                blue_difference;
	logic [7:0]                red_difference;
	int                        mismatches;
	int                        pending;
	int                        blocks_seen;

	int gap_odds;     // sender idles with chance 1 in gap_odds per word, 0 = never
	int stall_odds;   // receiver stalls with chance 1 in stall_odds per cycle, 0 = never
	int hold_reqs;    // long hold-offs asked of the receiver so far
	int row_pixels;
	int pixels_sent;
	int widths_used;

	rgb_to_yuv420_stream_unit u_top (.*);
	yuv420_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#(20 * 1000000);
		$display("run timed out with %0d words outstanding", pending);
		$display("end of test: mismatches");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off per request
	initial begin
		int holds_done;
		holds_done = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_OFF) @(negedge clk);
				result_stall <= 1'b0;
				holds_done++;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// write the width register; called at a falling edge with the block idle
	task automatic set_width(input logic [r2y_pkg::CFG_W-1:0] w);
		int eff;
		eff = (w == 0) ? 1 : ((w > r2y_pkg::MAX_PAIRS_DEFAULT) ?
			r2y_pkg::MAX_PAIRS_DEFAULT : int'(w));
		row_pixels = 2 * eff;
		cfg_valid <= 1'b1;
		pairs_per_row <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		widths_used++;
	endtask

	// offer one pixel word; returns at the falling edge after it is taken
	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic sof);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		start_of_frame <= sof;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		@(negedge clk);
		pixels_sent++;
	endtask

	// sender stops and waits until every predicted word has come back
	task automatic wait_drained();
		pixel_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// with one pair per row, four equal pixels make one 2x2 block
	task automatic push_block(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b, input logic sof);
		push_pixel(r, g, b, sof);
		repeat (3) push_pixel(r, g, b, 1'b0);
	endtask

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// whole frames of random pixels, some ending on a partial or unpaired row,
	// with an occasional stray start of frame breaking a row or a pair
	task automatic run_frames(input int count, input int hold_at);
		int left_in_frame;
		bit sof;
		left_in_frame = 0;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) hold_reqs++;
			sof = (left_in_frame <= 0) || ($urandom_range(1, 40) == 1);
			if (sof) begin
				left_in_frame = row_pixels * $urandom_range(2, 5);
				if ($urandom_range(0, 3) == 0)
					left_in_frame += $urandom_range(1, row_pixels);
			end
			push_pixel(pick_level(), pick_level(), pick_level(), sof);
			left_in_frame--;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		pairs_per_row = r2y_pkg::CFG_W'(r2y_pkg::PAIRS_RESET);
		pixel_valid = 1'b0;
		red = 8'h00;
		green = 8'h00;
		blue = 8'h00;
		start_of_frame = 1'b0;
		hold_reqs = 0;
		gap_odds = 4;
		stall_odds = 4;
		row_pixels = 2 * r2y_pkg::PAIRS_RESET;
		pixels_sent = 0;
		widths_used = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: black, white, blocks that clamp Cr high and Cb high, and a yellow block with low Cb
		set_width(12'd1);
		push_block(8'h00, 8'h00, 8'h00, 1'b1);
		push_block(8'hFF, 8'hFF, 8'hFF, 1'b0);
		push_block(8'hFF, 8'h00, 8'h00, 1'b0);
		push_block(8'h00, 8'h00, 8'hFF, 1'b0);
		push_block(8'hFF, 8'hFF, 8'h00, 1'b0);
		// even row with no partner row, then half a pair cut off by a new frame
		push_pixel(8'd17, 8'd200, 8'd3, 1'b0);
		push_pixel(8'd90, 8'd1, 8'd254, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		// checkerboard block: averaging of unequal pixels
		push_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
		push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
		push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
		wait_drained();

		// zero width acts as one pair
		set_width(12'd0);
		run_frames(120, -1);
		wait_drained();

		// three pairs, with a full sender pause in the middle
		set_width(12'd3);
		run_frames(80, -1);
		wait_drained();
		run_frames(80, -1);
		wait_drained();

		// steady sender while the receiver holds off long enough to back up input
		gap_odds = 0;
		stall_odds = 0;
		set_width(12'($urandom_range(4, 40)));
		run_frames(250, 30);
		wait_drained();

		// widest setting clamps to the line buffer depth: part of the first row
		gap_odds = 5;
		stall_odds = 5;
		set_width(12'hFFF);
		for (int i = 0; i < WIDE_PIXELS; i++)
			push_pixel(pick_level(), pick_level(), pick_level(), i == 0);
		wait_drained();

		// closing stretch with no idling on either side
		gap_odds = 0;
		stall_odds = 0;
		set_width(12'($urandom_range(1, 12)));
		run_frames(200, -1);
		wait_drained();

		$display("covered %0d pixels over %0d width settings, %0d chroma blocks",
			pixels_sent, widths_used, blocks_seen);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
